// ===== hw/rtl/str_pkg.sv =====
package str_pkg;

   // shared divider
   localparam int DIV_BITS     = 64;
   localparam int DIV_CNT_BITS = 7;

   // field and register widths
   localparam int MODE_BITS      = 2;
   localparam int VALUE_BITS     = 32;
   localparam int ACCEL_BITS     = 20;
   localparam int INTERVAL_BITS  = 32;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = 2;
   localparam int STOP_BITS      = 63;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ACCEL_RATE     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_INTERVAL = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_INTERVAL   = 2'd2;

   // register reset values
   localparam logic [ACCEL_BITS-1:0]    ACCEL_RESET = 20'd1000;
   localparam logic [INTERVAL_BITS-1:0] START_RESET = 32'd8095488;
   localparam logic [INTERVAL_BITS-1:0] MIN_RESET   = 32'd256000;

   // item modes
   localparam logic [MODE_BITS-1:0] MODE_TICK     = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_MOVE_ABS = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_MOVE_REL = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_SET_POS  = 2'd3;

   localparam logic signed [31:0]            RAMP_MAX  = 32'sh7FFF_FFFF;
   localparam logic [STOP_BITS-1:0]          STOP_CAP  = 63'h4000_0000_0000_0000;
   localparam logic [32:0]                   DEC_LIMIT = 33'h0_8000_0000;
   localparam logic [DIV_CNT_BITS-1:0]       STOP_ITER = 7'd64;
   localparam logic [DIV_CNT_BITS-1:0]       QUOT_ITER = 7'd33;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_REC,
      ST_SPD_WAIT,
      ST_SQUARE,
      ST_STOP_START,
      ST_STOP_WAIT,
      ST_DECIDE,
      ST_Q_START,
      ST_Q_WAIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                    start;
      logic [DIV_CNT_BITS-1:0] count;
   } div_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

// ===== hw/rtl/str_div.sv =====
module str_div (
   input  logic                           clock,
   input  logic                           reset,
   input  str_pkg::div_cmd_type           div_cmd,
   input  logic [str_pkg::DIV_BITS-1:0]   dividend,
   input  logic [str_pkg::DIV_BITS-1:0]   divisor,
   output logic [str_pkg::DIV_BITS-1:0]   quotient,
   output str_pkg::div_sts_type           div_sts
);
   import str_pkg::*;

   logic [DIV_BITS-1:0]     rem_ff, rem_in;
   logic [DIV_BITS-1:0]     num_ff, num_in;
   logic [DIV_BITS-1:0]     quot_ff, quot_in;
   logic [DIV_BITS-1:0]     divisor_ff, divisor_in;
   logic [DIV_CNT_BITS-1:0] count_ff, count_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;

   logic [DIV_BITS:0] trial;
   logic [DIV_BITS:0] diff;
   logic              fits;

   // one quotient bit per cycle, dividend enters left aligned
   assign trial = {rem_ff, num_ff[DIV_BITS-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = (trial >= {1'b0, divisor_ff});

   always_comb begin
      rem_in     = rem_ff;
      num_in     = num_ff;
      quot_in    = quot_ff;
      divisor_in = divisor_ff;
      count_in   = count_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (div_cmd.start) begin
         rem_in     = '0;
         num_in     = dividend;
         quot_in    = '0;
         divisor_in = divisor;
         count_in   = div_cmd.count;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
         num_in   = {num_ff[DIV_BITS-2:0], 1'b0};
         quot_in  = {quot_ff[DIV_BITS-2:0], fits};
         count_in = count_ff - DIV_CNT_BITS'(1);
         if (count_ff == DIV_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff     <= rem_in;
      num_ff     <= num_in;
      quot_ff    <= quot_in;
      divisor_ff <= divisor_in;
   end

   assign quotient     = quot_ff;
   assign div_sts.busy = busy_ff;
   assign div_sts.done = done_ff;

   a_done_after_busy : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a running division");

   a_busy_holds : assert property (@(posedge clock) disable iff (reset)
      (busy_ff && count_ff > DIV_CNT_BITS'(1) && !div_cmd.start) |=> busy_ff)
      else $error("divider stopped before its last quotient bit");

   a_start_count : assert property (@(posedge clock) disable iff (reset)
      div_cmd.start |-> (div_cmd.count != '0))
      else $error("division started with no iterations");

endmodule

// ===== hw/rtl/stepper_trapezoid_ramp.sv =====
// Stepper pulse generator with a trapezoidal speed ramp.
// Request channel (req_valid, req_stall, req_mode, req_value): each item is a
// one-tick time step, an absolute move, a relative move or a set-position.
// Response channel (rsp_valid, rsp_stall, ...): exactly one item per request
// with the step pulse flag, direction, position, distance left and moving.
// Configuration (csr_we, csr_index, csr_wdata): acceleration rate, start
// interval and minimum interval; write only while no item is in flight.
// An item that needs no ramp update (non-due tick, same target, set position)
// goes from decode straight to the response register; a new target from rest
// loads the start interval without a division. A due tick or a new target while
// moving runs the ramp update on one shared restoring divider at one quotient
// bit per cycle: speed ($clog2(TICKS_PER_SECOND + 1) + 2*FRACTION_BITS bits),
// stopping distance (64 bits) and, unless the motor stops, interval step (33
// bits). One item is worked on at a time and req_stall is high until its
// response is registered.
// A finished response waits in its output register while rsp_stall is high;
// the next request is accepted meanwhile, and its result waits in turn.
// Reset (synchronous): position, target, ramp count and interval clear,
// direction is clockwise, registers take their default values.
module stepper_trapezoid_ramp #(
   parameter int POSITION_BITS    = 32,
   parameter int FRACTION_BITS    = 8,
   parameter int TICKS_PER_SECOND = 1000000
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [str_pkg::MODE_BITS-1:0]         req_mode,
   input  logic signed [str_pkg::VALUE_BITS-1:0] req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_step_pulse,
   output logic                                  rsp_direction,
   output logic signed [31:0]                    rsp_position_now,
   output logic signed [31:0]                    rsp_distance_left,
   output logic                                  rsp_moving,
   input  logic                                  csr_we,
   input  logic [str_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [str_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   import str_pkg::*;

   localparam int EXT_BITS = (POSITION_BITS > 32) ? POSITION_BITS : 32;
   localparam int NUM_BITS = $clog2(TICKS_PER_SECOND + 1) + 2 * FRACTION_BITS;
   localparam int DUE_BITS = INTERVAL_BITS + FRACTION_BITS;
   localparam logic [DIV_BITS-1:0] SPD_NUM =
      DIV_BITS'(TICKS_PER_SECOND) << (2 * FRACTION_BITS);
   localparam logic [DIV_BITS-1:0] SPD_DIVIDEND = SPD_NUM << (DIV_BITS - NUM_BITS);
   localparam logic [DIV_CNT_BITS-1:0] SPD_ITER = DIV_CNT_BITS'(NUM_BITS);

   // control and state
   state_type                 state_ff, state_in;
   logic [MODE_BITS-1:0]      mode_ff, mode_in;
   logic signed [VALUE_BITS-1:0] value_ff, value_in;
   logic [POSITION_BITS-1:0]  position_ff, position_in;
   logic [POSITION_BITS-1:0]  target_ff, target_in;
   logic signed [31:0]        ramp_ff, ramp_in;
   logic [INTERVAL_BITS-1:0]  interval_ff, interval_in;
   logic                      dir_ff, dir_in;
   logic [31:0]               elapsed_ff, elapsed_in;
   logic                      running_ff, running_in;
   logic                      pulse_ff, pulse_in;
   logic [31:0]               spd_ff, spd_in;
   logic [DIV_BITS-1:0]       sq_ff, sq_in;
   logic [STOP_BITS-1:0]      stop_ff, stop_in;

   // configuration registers
   logic [ACCEL_BITS-1:0]     accel_ff;
   logic [INTERVAL_BITS-1:0]  start_ff;
   logic [INTERVAL_BITS-1:0]  min_ff;

   // response register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_pulse_ff, rsp_pulse_in;
   logic                      rsp_dir_ff, rsp_dir_in;
   logic signed [31:0]        rsp_pos_ff, rsp_pos_in;
   logic signed [31:0]        rsp_left_ff, rsp_left_in;
   logic                      rsp_moving_ff, rsp_moving_in;

   // shared divider
   div_cmd_type               div_cmd;
   div_sts_type               div_sts;
   logic [DIV_BITS-1:0]       div_dividend;
   logic [DIV_BITS-1:0]       div_divisor;
   logic [DIV_BITS-1:0]       div_quot;

   str_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_cmd  (div_cmd),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quot),
      .div_sts  (div_sts)
   );

   // datapath helpers
   logic signed [EXT_BITS-1:0] value_ext;
   logic [POSITION_BITS-1:0]   value_pos;
   logic [POSITION_BITS-1:0]   rel_target;
   logic [POSITION_BITS-1:0]   left_pos;
   logic signed [EXT_BITS-1:0] left_ext;
   logic signed [EXT_BITS-1:0] pos_ext;
   logic signed [63:0]         left64;
   logic signed [63:0]         left_abs;
   logic signed [63:0]         stop64;
   logic [31:0]               elapsed_inc;
   logic                      step_due;
   logic [32:0]               dec_mag;
   logic signed [32:0]        dec33;
   logic signed [32:0]        ramp33;
   logic signed [32:0]        ramp_neg33;
   logic signed [32:0]        ramp_new33;
   logic signed [31:0]        ramp_sel;
   logic signed [31:0]        ramp_inc;
   logic signed [34:0]        den35;
   logic signed [34:0]        den_neg;
   logic [33:0]               den_mag;
   logic [32:0]               quot33;
   logic [33:0]               c_sum;
   logic [INTERVAL_BITS-1:0]  c_sat;
   logic [INTERVAL_BITS-1:0]  c_min;
   logic [INTERVAL_BITS-1:0]  c_new;
   logic [INTERVAL_BITS-1:0]  c_start;

   assign value_ext  = EXT_BITS'(value_ff);
   assign value_pos  = value_ext[POSITION_BITS-1:0];
   assign rel_target = position_ff + value_pos;
   assign left_pos   = target_ff - position_ff;
   assign left_ext   = EXT_BITS'(signed'(left_pos));
   assign pos_ext    = EXT_BITS'(signed'(position_ff));
   assign left64     = 64'(signed'(left_pos));
   assign left_abs   = left64[63] ? -left64 : left64;
   assign stop64     = signed'({1'b0, stop_ff});

   assign elapsed_inc = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 32'd1;
   assign step_due = running_ff && (left_pos != '0) && (interval_ff != '0) &&
                     ((DUE_BITS'(elapsed_inc) << FRACTION_BITS) > DUE_BITS'(interval_ff));

   // deceleration loads minus the stopping distance, limited to 2^31
   assign dec_mag    = (stop_ff > STOP_BITS'(DEC_LIMIT)) ? DEC_LIMIT : stop_ff[32:0];
   assign dec33      = -signed'(dec_mag);
   assign ramp33     = 33'(ramp_ff);
   assign ramp_neg33 = -ramp33;

   always_comb begin
      ramp_new33 = ramp33;
      if (left64 > 64'sd0) begin
         if (ramp_ff > 32'sd0) begin
            if (stop64 >= left64 || !dir_ff) ramp_new33 = dec33;
         end else if (ramp_ff < 32'sd0) begin
            if (stop64 < left64 && dir_ff) ramp_new33 = ramp_neg33;
         end
      end else if (left64 < 64'sd0) begin
         if (ramp_ff > 32'sd0) begin
            if (stop64 >= left_abs || dir_ff) ramp_new33 = dec33;
         end else if (ramp_ff < 32'sd0) begin
            if (stop64 < left_abs && !dir_ff) ramp_new33 = ramp_neg33;
         end
      end
   end

   assign ramp_sel = (ramp_new33 > 33'(RAMP_MAX)) ? RAMP_MAX : ramp_new33[31:0];
   assign ramp_inc = (ramp_ff == RAMP_MAX) ? ramp_ff : ramp_ff + 32'sd1;

   // interval step c -/+ 2c / |4n+1|
   assign den35   = (35'(ramp_ff) <<< 2) + 35'sd1;
   assign den_neg = -den35;
   assign den_mag = den35[34] ? den_neg[33:0] : den35[33:0];
   assign quot33  = div_quot[32:0];
   assign c_sum   = den35[34] ? (34'(interval_ff) + 34'(quot33))
                              : (34'(interval_ff) - 34'(quot33));
   assign c_sat   = (c_sum[33:32] != 2'b00) ? '1 : c_sum[31:0];
   assign c_min   = (c_sat < min_ff) ? min_ff : c_sat;
   assign c_new   = (c_min == '0) ? INTERVAL_BITS'(1) : c_min;
   assign c_start = (start_ff == '0) ? INTERVAL_BITS'(1) : start_ff;

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      value_in      = value_ff;
      position_in   = position_ff;
      target_in     = target_ff;
      ramp_in       = ramp_ff;
      interval_in   = interval_ff;
      dir_in        = dir_ff;
      elapsed_in    = elapsed_ff;
      running_in    = running_ff;
      pulse_in      = pulse_ff;
      spd_in        = spd_ff;
      sq_in         = sq_ff;
      stop_in       = stop_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_pulse_in  = rsp_pulse_ff;
      rsp_dir_in    = rsp_dir_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_left_in   = rsp_left_ff;
      rsp_moving_in = rsp_moving_ff;
      div_cmd       = '0;
      div_dividend  = '0;
      div_divisor   = '0;
      req_stall     = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               mode_in  = req_mode;
               value_in = req_value;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            pulse_in = 1'b0;
            state_in = ST_FINISH;
            case (mode_ff)
               MODE_TICK: begin
                  elapsed_in = elapsed_inc;
                  if (step_due) begin
                     position_in = dir_ff ? position_ff + POSITION_BITS'(1)
                                          : position_ff - POSITION_BITS'(1);
                     elapsed_in  = '0;
                     pulse_in    = 1'b1;
                     state_in    = ST_REC;
                  end
               end
               MODE_MOVE_ABS: begin
                  if (value_pos != target_ff) begin
                     target_in = value_pos;
                     state_in  = ST_REC;
                  end
               end
               MODE_MOVE_REL: begin
                  if (rel_target != target_ff) begin
                     target_in = rel_target;
                     state_in  = ST_REC;
                  end
               end
               MODE_SET_POS: begin
                  position_in = value_pos;
                  target_in   = value_pos;
                  ramp_in     = '0;
                  interval_in = '0;
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_REC: begin
            if (running_ff && interval_ff != '0) begin
               div_cmd.start = 1'b1;
               div_cmd.count = SPD_ITER;
               div_dividend  = SPD_DIVIDEND;
               div_divisor   = DIV_BITS'(interval_ff);
               state_in      = ST_SPD_WAIT;
            end else begin
               stop_in  = '0;
               state_in = ST_DECIDE;
            end
         end
         ST_SPD_WAIT: begin
            if (div_sts.done) begin
               spd_in   = (div_quot[63:32] != '0) ? '1 : div_quot[31:0];
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            sq_in    = DIV_BITS'(spd_ff) * DIV_BITS'(spd_ff);
            state_in = ST_STOP_START;
         end
         ST_STOP_START: begin
            div_cmd.start = 1'b1;
            div_cmd.count = STOP_ITER;
            div_dividend  = sq_ff;
            div_divisor   = DIV_BITS'({accel_ff, 1'b0}) << (2 * FRACTION_BITS);
            state_in      = ST_STOP_WAIT;
         end
         ST_STOP_WAIT: begin
            if (div_sts.done) begin
               stop_in  = (div_quot > DIV_BITS'(STOP_CAP)) ? STOP_CAP
                                                           : div_quot[STOP_BITS-1:0];
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (left_pos == '0 && stop_ff <= STOP_BITS'(1)) begin
               // target reached at a crawl: stop
               interval_in = '0;
               running_in  = 1'b0;
               ramp_in     = '0;
               state_in    = ST_FINISH;
            end else if (ramp_sel == 32'sd0) begin
               // first step from rest
               interval_in = c_start;
               dir_in      = (left64 > 64'sd0);
               ramp_in     = 32'sd1;
               running_in  = 1'b1;
               state_in    = ST_FINISH;
            end else begin
               ramp_in  = ramp_sel;
               state_in = ST_Q_START;
            end
         end
         ST_Q_START: begin
            div_cmd.start = 1'b1;
            div_cmd.count = QUOT_ITER;
            div_dividend  = {interval_ff, 1'b0, 31'b0};
            div_divisor   = DIV_BITS'(den_mag);
            state_in      = ST_Q_WAIT;
         end
         ST_Q_WAIT: begin
            if (div_sts.done) begin
               interval_in = c_new;
               ramp_in     = ramp_inc;
               running_in  = 1'b1;
               state_in    = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_pulse_in  = pulse_ff;
               rsp_dir_in    = dir_ff;
               rsp_pos_in    = pos_ext[31:0];
               rsp_left_in   = left_ext[31:0];
               rsp_moving_in = running_ff && (left_pos != '0);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         position_ff  <= '0;
         target_ff    <= '0;
         ramp_ff      <= '0;
         interval_ff  <= '0;
         dir_ff       <= 1'b1;
         elapsed_ff   <= '0;
         running_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         position_ff  <= position_in;
         target_ff    <= target_in;
         ramp_ff      <= ramp_in;
         interval_ff  <= interval_in;
         dir_ff       <= dir_in;
         elapsed_ff   <= elapsed_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      value_ff      <= value_in;
      pulse_ff      <= pulse_in;
      spd_ff        <= spd_in;
      sq_ff         <= sq_in;
      stop_ff       <= stop_in;
      rsp_pulse_ff  <= rsp_pulse_in;
      rsp_dir_ff    <= rsp_dir_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_left_ff   <= rsp_left_in;
      rsp_moving_ff <= rsp_moving_in;
   end

   // a zero acceleration write is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         accel_ff <= ACCEL_RESET;
         start_ff <= START_RESET;
         min_ff   <= MIN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ACCEL_RATE: begin
               if (csr_wdata[ACCEL_BITS-1:0] != '0) accel_ff <= csr_wdata[ACCEL_BITS-1:0];
            end
            CSR_START_INTERVAL: begin
               start_ff <= csr_wdata[INTERVAL_BITS-1:0];
            end
            CSR_MIN_INTERVAL: begin
               min_ff <= csr_wdata[INTERVAL_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_step_pulse    = rsp_pulse_ff;
   assign rsp_direction     = rsp_dir_ff;
   assign rsp_position_now  = rsp_pos_ff;
   assign rsp_distance_left = rsp_left_ff;
   assign rsp_moving        = rsp_moving_ff;

   a_stopped_interval : assert property (@(posedge clock) disable iff (reset)
      !running_ff |-> (interval_ff == '0))
      else $error("stopped with a nonzero step interval");

   a_div_free : assert property (@(posedge clock) disable iff (reset)
      div_cmd.start |-> !div_sts.busy)
      else $error("division started while the divider is busy");

   a_ramp_idle : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && !reset) |=> $stable(ramp_ff))
      else $error("ramp count changed with no item in flight");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import str_pkg::*;

   localparam int                FRAC           = 8;
   localparam longint unsigned   TICKS_PER_SEC  = 64'd1000000;
   localparam longint unsigned   STOP_CAP_STEPS = 64'h4000_0000_0000_0000;
   localparam longint            RAMP_LIMIT     = 64'sd2147483647;
   localparam int                WATCHDOG_LIMIT = 5000;
   localparam int                TAIL_CYCLES    = 300;

   typedef struct packed {
      logic               step_pulse;
      logic               direction;
      logic signed [31:0] position_now;
      logic signed [31:0] distance_left;
      logic               moving;
   } motor_report_type;

   logic                    clock     = 1'b0;
   logic                    reset     = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [MODE_BITS-1:0]    req_mode  = MODE_TICK;
   logic signed [31:0]      req_value = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic                    rsp_step_pulse;
   logic                    rsp_direction;
   logic signed [31:0]      rsp_position_now;
   logic signed [31:0]      rsp_distance_left;
   logic                    rsp_moving;
   logic                    csr_we    = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_ACCEL_RATE;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // motor state tracked alongside the block
   logic [31:0]     motor_pos      = '0;
   logic [31:0]     motor_target   = '0;
   longint          motor_ramp     = 0;
   logic [31:0]     motor_interval = '0;
   logic            motor_dir      = 1'b1;
   logic [31:0]     motor_elapsed  = '0;
   logic            motor_running  = 1'b0;
   logic [19:0]     cfg_accel      = ACCEL_RESET;
   logic [31:0]     cfg_start      = START_RESET;
   logic [31:0]     cfg_min        = MIN_RESET;

   motor_report_type pending_reports[$];
   int               failures     = 0;
   int               hold_left    = 0;
   bit               no_gaps      = 1'b0;
   int               quiet_cycles = 0;

   stepper_trapezoid_ramp dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_step_pulse    (rsp_step_pulse),
      .rsp_direction     (rsp_direction),
      .rsp_position_now  (rsp_position_now),
      .rsp_distance_left (rsp_distance_left),
      .rsp_moving        (rsp_moving),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // stopping distance in steps from the current speed
   function automatic longint unsigned stopping_distance();
      longint unsigned speed;
      longint unsigned square;
      longint unsigned stop_count;
      if (!motor_running || motor_interval == 0)
         return 0;
      speed = (TICKS_PER_SEC << (2 * FRAC)) / 64'(motor_interval);
      if (speed > 64'hFFFF_FFFF)
         speed = 64'hFFFF_FFFF;
      square = speed * speed;
      stop_count = square / (64'(cfg_accel) << (2 * FRAC + 1));
      if (stop_count > STOP_CAP_STEPS)
         stop_count = STOP_CAP_STEPS;
      return stop_count;
   endfunction

   function automatic void update_ramp();
      logic [31:0]     gap;
      longint          left_steps;
      longint          stop_s;
      longint          dec_load;
      longint          denom;
      longint unsigned stop;
      longint unsigned mag;
      longint unsigned quo;
      longint unsigned interval_next;
      gap = motor_target - motor_pos;
      left_steps = 64'($signed(gap));
      stop = stopping_distance();
      stop_s = stop;
      if (stop > 64'h8000_0000)
         dec_load = -64'sd2147483648;
      else
         dec_load = -stop_s;

      if (left_steps == 0 && stop <= 1) begin
         motor_interval = '0;
         motor_running = 1'b0;
         motor_ramp = 0;
         return;
      end
      // pick accelerate, decelerate or reverse
      if (left_steps > 0) begin
         if (motor_ramp > 0) begin
            if (stop_s >= left_steps || !motor_dir)
               motor_ramp = dec_load;
         end else if (motor_ramp < 0) begin
            if (stop_s < left_steps && motor_dir)
               motor_ramp = -motor_ramp;
         end
      end else if (left_steps < 0) begin
         if (motor_ramp > 0) begin
            if (stop_s >= -left_steps || motor_dir)
               motor_ramp = dec_load;
         end else if (motor_ramp < 0) begin
            if (stop_s < -left_steps && !motor_dir)
               motor_ramp = -motor_ramp;
         end
      end
      if (motor_ramp > RAMP_LIMIT)
         motor_ramp = RAMP_LIMIT;

      if (motor_ramp == 0) begin
         interval_next = (cfg_start != 0) ? 64'(cfg_start) : 64'd1;
         motor_dir = (left_steps > 0);
      end else begin
         denom = 4 * motor_ramp + 1;
         mag = (denom > 0) ? denom : -denom;
         interval_next = 64'(motor_interval);
         quo = (2 * interval_next) / mag;
         if (denom > 0)
            interval_next = interval_next - quo;
         else
            interval_next = interval_next + quo;
         if (interval_next > 64'hFFFF_FFFF)
            interval_next = 64'hFFFF_FFFF;
         if (interval_next < 64'(cfg_min))
            interval_next = 64'(cfg_min);
         if (interval_next == 0)
            interval_next = 1;
      end
      if (motor_ramp < RAMP_LIMIT)
         motor_ramp++;
      motor_interval = interval_next[31:0];
      motor_running = 1'b1;
   endfunction

   function automatic void retarget(input logic [31:0] goal);
      if (goal != motor_target) begin
         motor_target = goal;
         update_ramp();
      end
   endfunction

   function automatic motor_report_type apply_item(input logic [1:0] mode,
                                                   input logic [31:0] value);
      motor_report_type rep;
      logic [31:0]      left;
      rep.step_pulse = 1'b0;
      case (mode)
         MODE_TICK: begin
            if (motor_elapsed != 32'hFFFF_FFFF)
               motor_elapsed++;
            if (motor_running && motor_target != motor_pos && motor_interval != 0 &&
                (64'(motor_elapsed) << FRAC) > 64'(motor_interval)) begin
               motor_pos = motor_dir ? motor_pos + 32'd1 : motor_pos - 32'd1;
               motor_elapsed = '0;
               rep.step_pulse = 1'b1;
               update_ramp();
            end
         end
         MODE_MOVE_ABS: retarget(value);
         MODE_MOVE_REL: retarget(motor_pos + value);
         MODE_SET_POS: begin
            motor_pos = value;
            motor_target = value;
            motor_ramp = 0;
            motor_interval = '0;
         end
         default: begin
         end
      endcase
      left = motor_target - motor_pos;
      rep.direction = motor_dir;
      rep.position_now = motor_pos;
      rep.distance_left = left;
      rep.moving = motor_running && (left != 0);
      return rep;
   endfunction

   task automatic send_item(input logic [1:0] mode, input logic [31:0] value);
      while (!no_gaps && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_value <= value;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      pending_reports.push_back(apply_item(mode, value));
   endtask

   task automatic wait_for_reports();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_reports.size() != 0)
         @(posedge clock);
   endtask

   task automatic set_ramp_config(input logic [19:0] accel, input logic [31:0] start_iv,
                                  input logic [31:0] floor_iv);
      logic [11:0] junk;
      junk = 12'($urandom);
      csr_we <= 1'b1;
      csr_index <= CSR_ACCEL_RATE;
      csr_wdata <= {junk, accel};
      @(posedge clock);
      csr_index <= CSR_START_INTERVAL;
      csr_wdata <= start_iv;
      @(posedge clock);
      csr_index <= CSR_MIN_INTERVAL;
      csr_wdata <= floor_iv;
      @(posedge clock);
      csr_we <= 1'b0;
      // a zero acceleration leaves the old rate in place
      if (accel != 0)
         cfg_accel = accel;
      cfg_start = start_iv;
      cfg_min = floor_iv;
   endtask

   // mostly moves followed by runs of ticks, with some retargets and noise
   task automatic run_motion_phase(input int items);
      int          sent;
      int          pick;
      int          burst;
      logic [31:0] offset;
      sent = 0;
      while (sent < items) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            offset = $urandom_range(1, 24);
            if ($urandom_range(1))
               offset = -offset;
            if ($urandom_range(1))
               send_item(MODE_MOVE_REL, offset);
            else
               send_item(MODE_MOVE_ABS, motor_pos + offset);
            burst = $urandom_range(4, 40);
            repeat (burst) send_item(MODE_TICK, $urandom);
            sent += burst + 1;
         end else if (pick < 70) begin
            burst = $urandom_range(2, 20);
            repeat (burst) send_item(MODE_TICK, $urandom);
            sent += burst;
         end else if (pick < 78) begin
            // stop on the spot, or name the target already held
            if ($urandom_range(1))
               send_item(MODE_MOVE_ABS, motor_pos);
            else
               send_item(MODE_MOVE_REL, motor_target - motor_pos);
            sent++;
         end else if (pick < 86) begin
            send_item(MODE_SET_POS, $urandom_range(1) ? $urandom : $urandom_range(0, 50));
            sent++;
         end else begin
            send_item(2'($urandom_range(3)), $urandom);
            sent++;
         end
      end
   endtask

   task automatic test_default_setup();
      send_item(MODE_TICK, 32'hFFFF_FFFF);
      send_item(MODE_MOVE_ABS, 32'd0);
      send_item(MODE_MOVE_REL, 32'd0);
      send_item(MODE_MOVE_ABS, 32'd3);
      send_item(MODE_TICK, 32'd0);
      send_item(MODE_MOVE_REL, -32'sd6);
      send_item(MODE_SET_POS, 32'h7FFF_FFFF);
      send_item(MODE_SET_POS, 32'h8000_0000);
      send_item(MODE_MOVE_ABS, 32'h7FFF_FFFF);
      send_item(MODE_TICK, 32'h5555_5555);
      send_item(MODE_SET_POS, 32'd0);
      send_item(MODE_MOVE_ABS, 32'd0);
   endtask

   task automatic test_fast_ramp();
      wait_for_reports();
      set_ramp_config(20'd0, 32'd256, 32'd256);
      // run across the positive wrap, then turn around and stop on the spot
      send_item(MODE_SET_POS, 32'h7FFF_FFFE);
      send_item(MODE_MOVE_REL, 32'd3);
      repeat (8) send_item(MODE_TICK, $urandom);
      send_item(MODE_MOVE_REL, -32'sd5);
      repeat (2) send_item(MODE_TICK, $urandom);
      send_item(MODE_MOVE_ABS, motor_pos);
   endtask

   task automatic test_random_phases();
      logic [19:0] accel;
      logic [31:0] start_iv;
      int          k;
      wait_for_reports();
      set_ramp_config(20'hF_FFFF, 32'd256, 32'd256);
      run_motion_phase(160);
      wait_for_reports();
      set_ramp_config(20'd1, 32'd2560, 32'd256);
      run_motion_phase(160);
      wait_for_reports();
      set_ramp_config(20'hF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      run_motion_phase(40);
      wait_for_reports();
      // zero start interval, and a long stretch with both sides always ready
      set_ramp_config(20'd5000, 32'd0, 32'd256);
      no_gaps = 1'b1;
      run_motion_phase(160);
      no_gaps = 1'b0;
      for (k = 0; k < 3; k++) begin
         wait_for_reports();
         accel = 20'($urandom_range(1, 20'hF_FFFF));
         start_iv = $urandom_range(256, 5120);
         set_ramp_config(accel, start_iv, $urandom_range(256, start_iv));
         run_motion_phase(130);
      end
   endtask

   task automatic test_backpressure();
      hold_left = 400;
      send_item(MODE_MOVE_REL, 32'd6);
      repeat (11) send_item(MODE_TICK, $urandom);
   endtask

   task automatic test_drain_pause();
      run_motion_phase(20);
      wait_for_reports();
      run_motion_phase(20);
   endtask

   // result checker and receiver stalls
   initial begin
      motor_report_type got;
      motor_report_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got = {rsp_step_pulse, rsp_direction, rsp_position_now, rsp_distance_left,
                   rsp_moving};
            if (pending_reports.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("unexpected item: pulse %0b dir %0b pos %0d left %0d moving %0b",
                           got.step_pulse, got.direction, got.position_now,
                           got.distance_left, got.moving);
            end else begin
               want = pending_reports.pop_front();
               if (got !== want) begin
                  failures++;
                  if (failures <= 10) begin
                     $display("mismatch expected: pulse %0b dir %0b pos %0d left %0d moving %0b",
                              want.step_pulse, want.direction, want.position_now,
                              want.distance_left, want.moving);
                     $display("         actual:   pulse %0b dir %0b pos %0d left %0d moving %0b",
                              got.step_pulse, got.direction, got.position_now,
                              got.distance_left, got.moving);
                  end
               end
            end
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= !no_gaps && ($urandom_range(99) < 34);
         end
      end
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we)
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_default_setup();
      test_fast_ramp();
      test_random_phases();
      test_backpressure();
      test_drain_pause();
      wait_for_reports();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (failures == 0 && pending_reports.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/str_pkg.sv
hw/rtl/str_div.sv
hw/rtl/stepper_trapezoid_ramp.sv
tb/sv/testbench.sv
